FILE: hw/rtl/packed_symmetric_matrix_reduce_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for packed_symmetric_matrix_reduce
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef PACKED_SYMMETRIC_MATRIX_REDUCE_MACROS_SVH
`define PACKED_SYMMETRIC_MATRIX_REDUCE_MACROS_SVH

// same-cycle implication
`define PSMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psmr assertion failed");

// next-cycle implication
`define PSMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psmr assertion failed");

`endif

FILE: hw/rtl/psmr_pkg.sv
// ----------------------------------------------------------------------------
// psmr_pkg
// Widths, defaults and the result record of the packed symmetric matrix reduce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psmr_pkg;

    localparam int MAX_ORDER_DEFAULT    = 16;
    localparam int ELEMENT_BITS_DEFAULT = 32;

    localparam int ORDER_W     = 5;
    localparam int ORDER_RESET = 16;
    localparam int ORDER_EXT_W = 7;

    localparam int SUM_W = 40;
    localparam int ABS_W = 39;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 160;

    typedef struct packed {
        logic [POS_W-1:0]        max_position;
        logic [POS_W-1:0]        min_position;
        logic signed [VAL_W-1:0] max_value;
        logic signed [VAL_W-1:0] min_value;
        logic [ABS_W-1:0]        abs_sum;
        logic signed [SUM_W-1:0] full_sum;
    } psmr_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psmr_accum.sv
// ----------------------------------------------------------------------------
// psmr_accum
// Row and column tracking, running sums and min/max search over one triangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packed_symmetric_matrix_reduce_macros.svh"

module psmr_accum
    import psmr_pkg::*;
#(
    parameter int MAX_ORDER    = MAX_ORDER_DEFAULT,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [ORDER_W-1:0]   cfg_wr_data,
    input  wire logic                 item_fire,
    input  wire logic [IN_DATA_W-1:0] item_data,
    output logic                      item_is_last,
    output logic                      result_fire,
    output psmr_result_t              result
);

    localparam int CNT_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int RESET_ORDER = (ORDER_RESET < MAX_ORDER) ? ORDER_RESET : MAX_ORDER;
    localparam logic [ORDER_EXT_W-1:0] MAX_ORDER_V = ORDER_EXT_W'(MAX_ORDER);

    logic [CNT_W-1:0]        last_idx_reg, last_idx_next;
    logic [CNT_W-1:0]        row_reg, row_next;
    logic [CNT_W-1:0]        col_reg, col_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [SUM_W-1:0]        abs_reg, abs_next;
    logic signed [VAL_W-1:0] min_reg, min_next;
    logic signed [VAL_W-1:0] max_reg, max_next;
    logic [POS_W-1:0]        min_pos_reg, min_pos_next;
    logic [POS_W-1:0]        max_pos_reg, max_pos_next;

    logic signed [ELEMENT_BITS-1:0] elem;
    logic signed [SUM_W-1:0]        val_ext;
    logic [SUM_W-1:0]               term;
    logic [SUM_W-1:0]               mag;
    logic signed [VAL_W-1:0]        val;
    logic [ORDER_EXT_W-1:0]         cfg_order;
    logic [CNT_W-1:0]               cfg_last;
    logic                           first;
    logic                           upd_min;
    logic                           upd_max;
    logic                           row_end;

    assign elem    = $signed(item_data[ELEMENT_BITS-1:0]);
    assign val_ext = SUM_W'(elem);
    assign val     = VAL_W'(elem);
    assign term    = (row_reg == col_reg) ? val_ext : {val_ext[SUM_W-2:0], 1'b0};
    assign mag     = val_ext[SUM_W-1] ? (~val_ext + SUM_W'(1)) : val_ext;

    assign first   = (pos_reg == '0);
    assign upd_min = first || (val < min_reg);
    assign upd_max = first || (val > max_reg);
    assign row_end = (col_reg >= last_idx_reg);

    assign item_is_last = row_end && (row_reg >= last_idx_reg);
    assign result_fire  = item_fire && item_is_last && !cfg_wr_en;

    assign cfg_order = ORDER_EXT_W'(cfg_wr_data);

    always_comb begin
        if (cfg_order == '0) begin
            cfg_last = '0;
        end else if (cfg_order > MAX_ORDER_V) begin
            cfg_last = CNT_W'(MAX_ORDER - 1);
        end else begin
            cfg_last = CNT_W'(cfg_order - ORDER_EXT_W'(1));
        end
    end

    always_comb begin
        sum_next     = sum_reg + term;
        abs_next     = abs_reg + mag;
        min_next     = upd_min ? val : min_reg;
        max_next     = upd_max ? val : max_reg;
        min_pos_next = upd_min ? pos_reg : min_pos_reg;
        max_pos_next = upd_max ? pos_reg : max_pos_reg;
        pos_next     = pos_reg + POS_W'(1);
        if (row_end) begin
            row_next = row_reg + CNT_W'(1);
            col_next = row_reg + CNT_W'(1);
        end else begin
            row_next = row_reg;
            col_next = col_reg + CNT_W'(1);
        end
        last_idx_next = cfg_wr_en ? cfg_last : last_idx_reg;
    end

    always_comb begin
        result.full_sum     = $signed(sum_next);
        result.abs_sum      = abs_next[ABS_W-1:0];
        result.min_value    = min_next;
        result.max_value    = max_next;
        result.min_position = min_pos_next;
        result.max_position = max_pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg <= CNT_W'(RESET_ORDER - 1);
            row_reg      <= '0;
            col_reg      <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            abs_reg      <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            min_pos_reg  <= '0;
            max_pos_reg  <= '0;
        end else begin
            last_idx_reg <= last_idx_next;
            if (cfg_wr_en || result_fire) begin
                row_reg     <= '0;
                col_reg     <= '0;
                pos_reg     <= '0;
                sum_reg     <= '0;
                abs_reg     <= '0;
                min_reg     <= '0;
                max_reg     <= '0;
                min_pos_reg <= '0;
                max_pos_reg <= '0;
            end else if (item_fire) begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                pos_reg     <= pos_next;
                sum_reg     <= sum_next;
                abs_reg     <= abs_next;
                min_reg     <= min_next;
                max_reg     <= max_next;
                min_pos_reg <= min_pos_next;
                max_pos_reg <= max_pos_next;
            end
        end
    end

    `PSMR_ASSERT_NEXT(a_clear_after_result, aclk, aresetn, result_fire, pos_reg == '0)
    `PSMR_ASSERT_NOW(a_col_not_below_row, aclk, aresetn, 1'b1, col_reg >= row_reg)
    `PSMR_ASSERT_NOW(a_row_in_range, aclk, aresetn, 1'b1, row_reg <= last_idx_reg)
    `PSMR_ASSERT_NOW(a_min_le_max, aclk, aresetn, result_fire,
                     result.min_value <= result.max_value)

endmodule

`default_nettype wire

FILE: hw/rtl/psmr_out_stage.sv
// ----------------------------------------------------------------------------
// psmr_out_stage
// Result register driving the master stream; frees itself as items are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psmr_out_stage
    import psmr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire psmr_result_t          result,
    output logic                       out_free,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic                  valid_reg, valid_next;
    logic [OUT_DATA_W-1:0] data_reg;

    assign out_free      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= OUT_DATA_W'({result.max_position, result.min_position,
                                     result.max_value, result.min_value,
                                     result.abs_sum, result.full_sum});
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/packed_symmetric_matrix_reduce.sv
// ----------------------------------------------------------------------------
// packed_symmetric_matrix_reduce
// Streams the packed upper triangle of a symmetric matrix and reports its sums
// and extremes once per triangle.
// ----------------------------------------------------------------------------
// Elements enter row-major (row a, columns a..n-1), one per cycle. Each item
// is held in the input register and is then folded into the running sums and
// min/max; the edge that folds in the last element of a triangle also writes
// the result register, so that element passes the input register and then the
// result register before m_axis_tvalid rises. Throughput is one item per cycle,
// set by the add and compare that feed the running registers; the input only
// waits when the last item of a triangle meets a result register still held by
// m_axis_tready low. Writing the order register restarts the triangle; order 0
// acts as 1 and orders above MAX_ORDER act as MAX_ORDER.
`timescale 1ns / 1ps
`default_nettype none

module packed_symmetric_matrix_reduce
    import psmr_pkg::*;
#(
    parameter int MAX_ORDER    = MAX_ORDER_DEFAULT,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [ORDER_W-1:0]    cfg_wr_data,   // order_in_use
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] element_value
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [39:0] full_sum, [78:40] abs_sum, [110:79] min_value, [142:111] max_value,
    // [150:143] min_position, [158:151] max_position, [159] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic                 in_valid_reg, in_valid_next;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 advance;
    logic                 item_is_last;
    logic                 result_fire;
    logic                 out_free;
    psmr_result_t         result;

    assign advance       = in_valid_reg && (!item_is_last || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata;
        end
    end

    psmr_accum #(
        .MAX_ORDER    (MAX_ORDER),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_fire    (advance),
        .item_data    (in_data_reg),
        .item_is_last (item_is_last),
        .result_fire  (result_fire),
        .result       (result)
    );

    psmr_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (result_fire),
        .result        (result),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
